// ----- src/frq_pkg.sv -----
// Types and codes for the FCFS/SPN ready queue.
// Shared by frq_cfg, frq_ctrl and the top level; depends on nothing.
package frq_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] REG_SPN_MODE = 2'd0;

  typedef struct packed {
    logic [15:0] job_id;
    logic        job_type;
    logic [31:0] remaining_time;
  } job_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] job_id;
    logic        job_type;
    logic [31:0] remaining_time;
  } cmd_in_t;

  typedef struct packed {
    logic        out_valid;
    logic [15:0] out_job_id;
    logic        out_job_type;
    logic [31:0] out_remaining_time;
    logic [1:0]  status;
    logic [4:0]  occupancy;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_POP
  } frq_state_t;

endpackage

// ----- src/frq_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependency.
module frq_ram #(
  parameter int W     = 49,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/frq_cfg.sv -----
// APB register block holding the spn_mode control bit.
// Depends on frq_pkg for register addresses.
module frq_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        spn_mode
);
  import frq_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      spn_mode <= 1'b0;
    end else if (wr_en && paddr == REG_SPN_MODE) begin
      spn_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_SPN_MODE) begin
      prdata = {31'd0, spn_mode};
    end
  end

endmodule

// ----- src/frq_ctrl.sv -----
// Queue sequencer: circular buffer over the job RAM, ordered insert walk and pop.
// Depends on frq_pkg; drives one frq_ram instance.
module frq_ctrl #(
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  frq_pkg::cmd_in_t item,
  input  logic             spn_mode,
  output logic             ram_we,
  output logic [AW-1:0]    ram_waddr,
  output frq_pkg::job_t    ram_wdata,
  output logic [AW-1:0]    ram_raddr,
  input  frq_pkg::job_t    ram_rdata,
  output logic             done,
  output frq_pkg::result_t result
);
  import frq_pkg::*;

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  frq_state_t      state, state_next;
  logic [AW-1:0]   head, head_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   pos, pos_next;
  logic [CW-1:0]   spec_rel;
  job_t            key, key_next;
  job_t            new_job;
  logic            done_next;
  result_t         result_next;

  // map a queue position (0 = head) to a RAM address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] rel);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(rel);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return AW'(s);
  endfunction

  assign busy = (state != S_IDLE);

  assign new_job = '{job_id: item.job_id, job_type: item.job_type,
                     remaining_time: item.remaining_time};

  // position two below pos, wrapped; read ahead while the walk shifts
  assign spec_rel = (pos >= CW'(2)) ? pos - CW'(2) : pos + DEPTH_C - CW'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    pos    <= pos_next;
    key    <= key_next;
    result <= result_next;
  end

  always_comb begin
    state_next  = state;
    head_next   = head;
    count_next  = count;
    pos_next    = pos;
    key_next    = key;
    done_next   = 1'b0;
    result_next = result;
    ram_we      = 1'b0;
    ram_waddr   = phys(head, count);
    ram_wdata   = key;
    ram_raddr   = phys(head, count - CW'(1));

    case (state)
      S_IDLE: begin
        if (start) begin
          key_next    = new_job;
          result_next = '0;
          if (item.cmd == CMD_INSERT) begin
            if (count == DEPTH_C) begin
              done_next             = 1'b1;
              result_next.status    = ST_FULL;
              result_next.occupancy = 5'(count);
            end else if (!spn_mode || count == '0) begin
              ram_we                = 1'b1;
              ram_waddr             = phys(head, count);
              ram_wdata             = new_job;
              count_next            = count + CW'(1);
              done_next             = 1'b1;
              result_next.status    = ST_OK;
              result_next.occupancy = 5'(count + CW'(1));
            end else begin
              ram_raddr  = phys(head, count - CW'(1));
              pos_next   = count;
              state_next = S_WALK;
            end
          end else begin
            if (count == '0) begin
              done_next             = 1'b1;
              result_next.status    = ST_EMPTY;
              result_next.occupancy = 5'(count);
            end else begin
              ram_raddr  = head;
              state_next = S_POP;
            end
          end
        end
      end

      S_WALK: begin
        // rdata holds the entry at pos-1
        ram_raddr = phys(head, spec_rel);
        if (pos == '0 || ram_rdata.remaining_time < key.remaining_time) begin
          ram_we                = 1'b1;
          ram_waddr             = phys(head, pos);
          ram_wdata             = key;
          count_next            = count + CW'(1);
          done_next             = 1'b1;
          result_next           = '0;
          result_next.status    = ST_OK;
          result_next.occupancy = 5'(count + CW'(1));
          state_next            = S_IDLE;
        end else begin
          // shift the equal or larger entry one place toward the tail
          ram_we    = 1'b1;
          ram_waddr = phys(head, pos);
          ram_wdata = ram_rdata;
          pos_next  = pos - CW'(1);
        end
      end

      S_POP: begin
        result_next.out_valid          = 1'b1;
        result_next.out_job_id         = ram_rdata.job_id;
        result_next.out_job_type       = ram_rdata.job_type;
        result_next.out_remaining_time = ram_rdata.remaining_time;
        result_next.status             = ST_OK;
        result_next.occupancy          = 5'(count - CW'(1));
        head_next                      = phys(head, CW'(1));
        count_next                     = count - CW'(1);
        done_next                      = 1'b1;
        state_next                     = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("queue count above depth");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result strobe while sequencer busy");

  a_walk_pos: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> (pos <= count && count < DEPTH_C))
    else $error("insert walk position out of range");

  a_valid_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result.out_valid) |-> result.status == ST_OK)
    else $error("removed job reported with error status");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    state == S_POP |=> (count == $past(count) - CW'(1) && done))
    else $error("pop did not retire one entry");

endmodule

// ----- src/fcfs_spn_ready_queue.sv -----
// Top level of the FCFS/SPN ready queue: APB registers, sequencer, job RAM.
// Depends on frq_pkg, frq_cfg, frq_ctrl and frq_ram.
//
//  channel   handshake                      payload
//  --------  -----------------------------  ----------------------------
//  command   start & !busy                  item (cmd_in_t)
//  result    done (one cycle, no stall)     result (result_t)
//  config    psel & penable & pwrite        paddr, pwdata (spn_mode @ 0)
//
// Status-only results, FCFS inserts and SPN inserts into an empty queue
// strobe done in the cycle after the transfer; a remove first reads the head
// entry from the RAM (registered read port), then registers the result; any
// other SPN insert shifts held jobs toward the tail (at most QUEUE_DEPTH - 1),
// one shift per cycle through the single RAM write port, before it writes.
// busy stays high until the result is registered. rst is synchronous and
// empties the queue and clears spn_mode; RAM contents are not cleared.
module fcfs_spn_ready_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [1:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             start,
  output logic             busy,
  input  frq_pkg::cmd_in_t item,
  output logic             done,
  output frq_pkg::result_t result
);
  import frq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic          spn_mode;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  job_t          ram_wdata;
  job_t          ram_rdata;

  frq_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .spn_mode (spn_mode)
  );

  frq_ctrl #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .spn_mode  (spn_mode),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .done      (done),
    .result    (result)
  );

  frq_ram #(
    .W     ($bits(job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for fcfs_spn_ready_queue: queued commands, an in-bench ready-queue
// predictor and a result checker; spn_mode is written over APB between phases.
// Depends on frq_pkg and the fcfs_spn_ready_queue RTL.
`timescale 1ns / 100ps

module tb;
  import frq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int SETTLE_CYCLES = QUEUE_DEPTH + 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  cmd_in_t     item = '0;
  logic        done;
  result_t     result;

  fcfs_spn_ready_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .item(item),
    .done(done), .result(result)
  );

  always #10 clk = ~clk;

  // predictor state
  job_t        ready_slots [QUEUE_DEPTH];
  int unsigned held_jobs = 0;
  logic        spn_order = 1'b0;

  cmd_in_t     cmd_backlog [$];
  result_t     owed_results [$];
  int          error_count = 0;
  bit          took_item = 1'b0;
  int          burst_left = 1;
  int          gap_left = 0;

  task automatic note_error(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string tag, logic [31:0] got, logic [31:0] want);
    if (got !== want) note_error($sformatf("%s got %0h want %0h", tag, got, want));
  endtask

  // append one command to the tail of the backlog
  task automatic add_cmd(cmd_in_t c);
    cmd_backlog = {cmd_backlog, c};
  endtask

  // Apply one command to the predicted queue and return the result it must cause.
  function automatic result_t schedule_command(cmd_in_t c);
    result_t r;
    int unsigned pos;
    r = '0;
    if (c.cmd == CMD_INSERT) begin
      if (held_jobs >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = held_jobs;
        // newest job goes ahead of every held job with an equal or larger time
        if (spn_order)
          while (pos > 0 && ready_slots[pos-1].remaining_time >= c.remaining_time) pos--;
        for (int unsigned k = held_jobs; k > pos; k--) ready_slots[k] = ready_slots[k-1];
        ready_slots[pos] = job_t'{c.job_id, c.job_type, c.remaining_time};
        held_jobs++;
        r.status = ST_OK;
      end
    end else if (held_jobs == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.out_valid = 1'b1;
      r.out_job_id = ready_slots[0].job_id;
      r.out_job_type = ready_slots[0].job_type;
      r.out_remaining_time = ready_slots[0].remaining_time;
      for (int unsigned k = 1; k < held_jobs; k++) ready_slots[k-1] = ready_slots[k];
      held_jobs--;
      r.status = ST_OK;
    end
    r.occupancy = 5'(held_jobs);
    return r;
  endfunction

  // monitor: check results, track config writes, predict on each command transfer
  always @(posedge clk) begin
    result_t want;
    result_t pred;
    took_item = 1'b0;
    if (rst) begin
      held_jobs = 0;
      spn_order = 1'b0;
    end else begin
      if (done) begin
        if (owed_results.size() == 0) begin
          note_error("result with nothing outstanding");
        end else begin
          want = owed_results.pop_front();
          check_field("out_valid", 32'(result.out_valid), 32'(want.out_valid));
          check_field("out_job_id", 32'(result.out_job_id), 32'(want.out_job_id));
          check_field("out_job_type", 32'(result.out_job_type), 32'(want.out_job_type));
          check_field("out_remaining_time", result.out_remaining_time,
                      want.out_remaining_time);
          check_field("status", 32'(result.status), 32'(want.status));
          check_field("occupancy", 32'(result.occupancy), 32'(want.occupancy));
        end
      end
      if (psel && penable && pwrite && pready && paddr == (REG_SPN_MODE << 2))
        spn_order = pwdata[0];
      if (start && !busy) begin
        took_item = 1'b1;
        pred = schedule_command(item);
        owed_results = {owed_results, pred};
      end
    end
  end

  // driver: present backlog items in bursts separated by random gaps
  always @(negedge clk) begin
    logic    nxt_start;
    cmd_in_t nxt_item;
    nxt_start = start;
    nxt_item = item;
    if (rst) begin
      nxt_start = 1'b0;
    end else begin
      if (start && took_item) nxt_start = 1'b0;
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() > 0) begin
          nxt_item = cmd_backlog.pop_front();
          nxt_start = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
    end
    start <= nxt_start;
    item <= nxt_item;
  end

  function automatic cmd_in_t insert_cmd(logic [15:0] id, logic kind, logic [31:0] t);
    cmd_in_t c;
    c.cmd = CMD_INSERT;
    c.job_id = id;
    c.job_type = kind;
    c.remaining_time = t;
    return c;
  endfunction

  // remove commands carry random junk in the job fields
  function automatic cmd_in_t remove_cmd();
    cmd_in_t c;
    c = insert_cmd(16'($urandom()), 1'($urandom()), $urandom());
    c.cmd = CMD_REMOVE;
    return c;
  endfunction

  // many small keys so that ties are common, plus the extremes
  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 7))
      0, 1, 2: return $urandom_range(0, 7);
      3:       return 32'hFFFF_FFFF;
      4:       return 32'd0;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_random_commands(int n);
    int made;
    int style;
    int seg;
    int ins_pct;
    made = 0;
    while (made < n) begin
      style = $urandom_range(0, 4);
      if (style == 4) begin
        // a run of inserts near the queue depth, then as many removes
        seg = $urandom_range(QUEUE_DEPTH - 2, QUEUE_DEPTH + 2);
        repeat (seg) add_cmd(insert_cmd(16'($urandom()), 1'($urandom()), pick_time()));
        repeat (seg) add_cmd(remove_cmd());
        made += 2 * seg;
      end else begin
        ins_pct = (style == 0) ? 90 : (style == 1) ? 25 : (style == 2) ? 55 : 70;
        seg = $urandom_range(5, 30);
        repeat (seg) begin
          if ($urandom_range(1, 100) <= ins_pct)
            add_cmd(insert_cmd(16'($urandom()), 1'($urandom()), pick_time()));
          else
            add_cmd(remove_cmd());
        end
        made += seg;
      end
    end
  endtask

  // hold until every queued command has transferred and every result has come back
  task automatic wait_quiet();
    bit quiet;
    quiet = 1'b0;
    while (!quiet) begin
      @(posedge clk);
      quiet = (cmd_backlog.size() == 0) && !start;
      @(negedge clk);
      quiet = quiet && (owed_results.size() == 0);
    end
  endtask

  task automatic write_spn_mode(logic mode);
    wait_quiet();
    repeat (SETTLE_CYCLES) @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_SPN_MODE << 2;
    pwdata <= {31'b0, mode};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    logic phase_modes [8];
    phase_modes = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // first come first served: empty remove, field extremes, arrival order
    write_spn_mode(1'b0);
    add_cmd(remove_cmd());
    add_cmd(insert_cmd(16'hFFFF, 1'b1, 32'hFFFF_FFFF));
    add_cmd(insert_cmd(16'h0000, 1'b0, 32'h0000_0000));
    add_cmd(remove_cmd());
    add_cmd(remove_cmd());
    add_cmd(remove_cmd());

    // shortest first: ties leave newest first, zero and max keys
    write_spn_mode(1'b1);
    add_cmd(insert_cmd(16'h0001, 1'b0, 32'd5));
    add_cmd(insert_cmd(16'h0002, 1'b1, 32'd5));
    add_cmd(insert_cmd(16'h0003, 1'b0, 32'hFFFF_FFFF));
    add_cmd(insert_cmd(16'h0004, 1'b1, 32'd0));
    add_cmd(insert_cmd(16'h0005, 1'b0, 32'd5));
    repeat (6) add_cmd(remove_cmd());

    foreach (phase_modes[p]) begin
      write_spn_mode(phase_modes[p]);
      queue_random_commands($urandom_range(88, 104));
      // let every queued command and its result finish mid-phase before sending more
      wait_quiet();
      queue_random_commands($urandom_range(88, 104));
    end

    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (owed_results.size() != 0)
      note_error($sformatf("%0d results never arrived", owed_results.size()));
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
